FILE: sv/cfifo_pkg.sv
// shared constants, types, request codes and pointer helpers for the circular fifo
// no dependencies; imported by cfifo_ctrl and circular_fifo_with_indexed_access

package cfifo_pkg;

    // queue geometry; slot indexing below assumes DEPTH is a power of two
    localparam int DEPTH      = 1024;
    localparam int ENTRY_BITS = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    // fixed port widths
    localparam int REQ_BITS   = 3;
    localparam int SEQ_BITS   = 64;
    localparam int AMT_BITS   = 11;
    localparam int OCC_BITS   = 11;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_PUSH        = 3'd0,
        REQ_PUSH_AT     = 3'd1,
        REQ_POP         = 3'd2,
        REQ_POP_MANY    = 3'd3,
        REQ_PEEK_FRONT  = 3'd4,
        REQ_PEEK_BACK   = 3'd5,
        REQ_READ_AT     = 3'd6,
        REQ_READ_BEFORE = 3'd7
    } t_req;

    typedef struct packed {
        logic                  ok;
        logic [ENTRY_BITS-1:0] value;
        logic [OCC_BITS-1:0]   occupancy;
        logic                  is_full;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  waddr;
        logic [ENTRY_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0]  raddr;
    } t_mem_req;

    function automatic logic [ADDR_BITS-1:0] ptr_next(input logic [ADDR_BITS-1:0] p);
        return (p == ADDR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_BITS-1:0] ptr_prev(input logic [ADDR_BITS-1:0] p);
        return (p == '0) ? ADDR_BITS'(DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

FILE: sv/cfifo_ram.sv
// simple dual-port synchronous ram, one write and one registered read per cycle
// no dependencies

module cfifo_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cfifo_ctrl.sv
// request sequencer: clearing pass, pointer and count state, read-modify-write of the slot ram
// depends on cfifo_pkg; drives the cfifo_ram ports through a t_mem_req struct

module cfifo_ctrl
    import cfifo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [ENTRY_BITS-1:0] i_entry_value,
    input  logic [SEQ_BITS-1:0]   i_seq_position,
    input  logic [AMT_BITS-1:0]   i_pop_amount,
    output t_mem_req              o_mem,
    input  logic [ENTRY_BITS-1:0] i_rd_data,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_take
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MPOP,
        S_DONE
    } t_state;

    t_state                r_state,    n_state;
    logic [ADDR_BITS-1:0]  r_head,     n_head;
    logic [ADDR_BITS-1:0]  r_tail,     n_tail;
    logic [CNT_BITS-1:0]   r_count,    n_count;
    logic [ADDR_BITS-1:0]  r_clr_addr, n_clr_addr;
    t_req                  r_req,      n_req;
    logic [ENTRY_BITS-1:0] r_value,    n_value;
    logic [ADDR_BITS-1:0]  r_seq_idx,  n_seq_idx;
    logic [AMT_BITS-1:0]   r_left,     n_left;
    t_result               r_res,      n_res;

    logic     full;
    logic     empty;
    t_req     in_req;
    t_mem_req mem;

    assign full   = (r_count == CNT_BITS'(DEPTH));
    assign empty  = (r_count == '0);
    assign in_req = t_req'(i_req_type);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_clr_addr = r_clr_addr;
        n_req      = r_req;
        n_value    = r_value;
        n_seq_idx  = r_seq_idx;
        n_left     = r_left;
        n_res      = r_res;
        mem.we     = 1'b0;
        mem.waddr  = r_head;
        mem.wdata  = '0;
        mem.raddr  = r_head;

        unique case (r_state)
            S_CLEAR: begin
                mem.we     = 1'b1;
                mem.waddr  = r_clr_addr;
                n_clr_addr = ptr_next(r_clr_addr);
                if (r_clr_addr == ADDR_BITS'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // read address issued in the accept cycle
                case (in_req)
                    REQ_PEEK_BACK:   mem.raddr = ptr_prev(r_tail);
                    REQ_READ_AT:     mem.raddr = i_seq_position[ADDR_BITS-1:0];
                    REQ_READ_BEFORE: mem.raddr = i_seq_position[ADDR_BITS-1:0] - 1'b1;
                    default:         mem.raddr = r_head;
                endcase
                if (i_in_valid) begin
                    n_req     = in_req;
                    n_value   = i_entry_value;
                    n_seq_idx = i_seq_position[ADDR_BITS-1:0];
                    n_left    = i_pop_amount;
                    n_state   = (in_req == REQ_POP_MANY) ? S_MPOP : S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.ok    = 1'b0;
                n_res.value = '0;
                case (r_req) inside
                    REQ_PUSH, REQ_PUSH_AT: begin
                        if (!full && (r_req == REQ_PUSH || r_tail == r_seq_idx)) begin
                            mem.we    = 1'b1;
                            mem.waddr = r_tail;
                            mem.wdata = r_value;
                            n_tail    = ptr_next(r_tail);
                            n_count   = r_count + 1'b1;
                            n_res.ok  = 1'b1;
                        end
                    end
                    REQ_POP: begin
                        if (!empty) begin
                            mem.we      = 1'b1;
                            mem.waddr   = r_head;
                            n_head      = ptr_next(r_head);
                            n_count     = r_count - 1'b1;
                            n_res.ok    = 1'b1;
                            n_res.value = i_rd_data;
                        end
                    end
                    REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
                        if (!empty) begin
                            n_res.ok    = 1'b1;
                            n_res.value = i_rd_data;
                        end
                    end
                    default: begin
                        // positional reads, no checks
                        n_res.ok    = 1'b1;
                        n_res.value = i_rd_data;
                    end
                endcase
                n_res.occupancy = OCC_BITS'(n_count);
                n_res.is_full   = (n_count == CNT_BITS'(DEPTH));
                n_state         = S_DONE;
            end
            S_MPOP: begin
                // one slot cleared per cycle
                n_res.value     = '0;
                n_res.occupancy = OCC_BITS'(r_count);
                n_res.is_full   = full;
                if (r_left == '0) begin
                    n_res.ok = 1'b1;
                    n_state  = S_DONE;
                end else if (empty) begin
                    n_res.ok = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    mem.we    = 1'b1;
                    mem.waddr = r_head;
                    n_head    = ptr_next(r_head);
                    n_count   = r_count - 1'b1;
                    n_left    = r_left - 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_clr_addr <= n_clr_addr;
        end
        r_req     <= n_req;
        r_value   <= n_value;
        r_seq_idx <= n_seq_idx;
        r_left    <= n_left;
        r_res     <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_mem       = mem;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count above depth");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ADDR_BITS'(r_tail - r_head) == r_count[ADDR_BITS-1:0])
        else $error("head, tail and count disagree");

    a_mpop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MPOP && r_left != '0 && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1 && r_head == ptr_next($past(r_head))))
        else $error("pop many did not remove one entry");

    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_req == REQ_PUSH && !full)
        |=> (r_res.ok && r_count == $past(r_count) + 1'b1))
        else $error("push with room failed");
`endif

endmodule

FILE: sv/circular_fifo_with_indexed_access.sv
// Sequence: a single-slot word goes from S_IDLE (accept, read issue) to S_EXEC (ram
//   read-modify-write) and S_DONE (hand-off to the output register); a pop-many word
//   removes min(pop_amount, occupancy) entries in S_MPOP, one ram write per entry.
// Flow: the sequencer handles one word at a time and accepts a new word only after the
//   last result is handed off. Reset: synchronous, active low; pointers and count clear
//   at once, then a clearing pass zeroes the slot ram with o_in_ready low.

module circular_fifo_with_indexed_access
    import cfifo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [ENTRY_BITS-1:0] i_entry_value,
    input  logic [SEQ_BITS-1:0]   i_seq_position,
    input  logic [AMT_BITS-1:0]   i_pop_amount,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [ENTRY_BITS-1:0] o_read_value,
    output logic [OCC_BITS-1:0]   o_occupancy,
    output logic                  o_is_full
);

    t_mem_req              mem;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                  res_valid;
    t_result               res;
    logic                  res_take;

    logic                  r_out_valid;
    t_result               r_out;

    // sequencer: owns head, tail, count and the clearing pass
    cfifo_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_entry_value  (i_entry_value),
        .i_seq_position (i_seq_position),
        .i_pop_amount   (i_pop_amount),
        .o_mem          (mem),
        .i_rd_data      (rd_data),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_take     (res_take)
    );

    // slot store, one write and one registered read per cycle
    cfifo_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    // output register: takes a finished result whenever it is empty or being drained,
    // so the sequencer goes back to idle and accepts the next word while this one waits
    assign res_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out.ok;
    assign o_read_value = r_out.value;
    assign o_occupancy  = r_out.occupancy;
    assign o_is_full    = r_out.is_full;

endmodule
